// File: hdl/e1tdc_pkg.sv
package e1tdc_pkg;

	localparam int FRAME_BYTES = 32;
	localparam int MAX_DEPTH = 8;
	localparam logic [4:0] LAST_TIMESLOT = 5'(FRAME_BYTES - 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_start;
		logic       packet_error;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  channel;
		logic [63:0] samples;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic take_byte;
		logic rd_issue;
	} e1tdc_cmd_t;

	typedef struct packed {
		logic chunk_end;
		logic out_busy;
		logic rd_last;
	} e1tdc_sts_t;

	typedef enum logic {
		ST_COLLECT,
		ST_DRAIN
	} e1tdc_state_t;

endpackage

// File: hdl/e1tdc_ram.sv
module e1tdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 31
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/e1tdc_ctrl.sv
module e1tdc_ctrl
	import e1tdc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  e1tdc_sts_t sts,
	output e1tdc_cmd_t cmd
);

	e1tdc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			ST_COLLECT: begin
				in_ready = 1'b1;
				cmd.take_byte = in_valid;
				if (in_valid && sts.chunk_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// One store read per cycle while the output register can take it.
				cmd.rd_issue = !sts.out_busy;
				if (!sts.out_busy && sts.rd_last) begin
					state_d = ST_COLLECT;
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

endmodule

// File: hdl/e1tdc_datapath.sv
module e1tdc_datapath
	import e1tdc_pkg::*;
#(
	parameter int CHANNELS = 31,
	parameter int CHUNK_DEPTH = 8,
	parameter int HEADER_BYTES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_data,
	input  logic       out_ready,
	input  e1tdc_cmd_t cmd,
	output e1tdc_sts_t sts,
	output logic       out_valid,
	output out_item_t  out_data
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [2:0] header_left_q;
	logic [4:0] slot_q;
	logic [2:0] frame_slot_q;
	logic [4:0] rd_ch_q;
	logic       out_valid_q;
	logic [4:0] out_ch_q;
	logic       out_last_q;

	logic [2:0] header_eff;
	logic [4:0] slot_eff;
	logic       frame_byte;
	logic       frame_end;
	logic       wr_en;
	logic [7:0] rd_byte [MAX_DEPTH];

	// A packet start restarts the framing before the byte itself is looked at.
	assign header_eff = in_data.packet_start ? 3'(HEADER_BYTES) : header_left_q;
	assign slot_eff = in_data.packet_start ? 5'd0 : slot_q;
	assign frame_byte = !in_data.packet_error && (header_eff == 3'd0);
	assign frame_end = frame_byte && (slot_eff == LAST_TIMESLOT);
	assign wr_en = cmd.take_byte && frame_byte && (slot_eff != 5'd0) &&
		(slot_eff <= 5'(CHANNELS));

	assign sts.chunk_end = frame_end && (frame_slot_q == 3'(CHUNK_DEPTH - 1));
	assign sts.out_busy = out_valid_q && !out_ready;
	assign sts.rd_last = (rd_ch_q == 5'(CHANNELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_left_q <= 3'(HEADER_BYTES);
			slot_q <= 5'd0;
			frame_slot_q <= 3'd0;
			rd_ch_q <= 5'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take_byte) begin
				if (in_data.packet_error) begin
					header_left_q <= header_eff;
					slot_q <= slot_eff;
				end else if (header_eff != 3'd0) begin
					header_left_q <= header_eff - 3'd1;
					slot_q <= slot_eff;
				end else if (frame_end) begin
					header_left_q <= header_eff;
					slot_q <= 5'd0;
					frame_slot_q <= sts.chunk_end ? 3'd0 : frame_slot_q + 3'd1;
				end else begin
					header_left_q <= header_eff;
					slot_q <= slot_eff + 5'd1;
				end
				if (sts.chunk_end) begin
					rd_ch_q <= 5'd1;
				end
			end
			if (cmd.rd_issue) begin
				rd_ch_q <= rd_ch_q + 5'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			out_ch_q <= rd_ch_q;
			out_last_q <= sts.rd_last;
		end
	end

	// One narrow store per frame slot, addressed by channel, so that a whole
	// chunk of one channel is read out together at one shared address.
	for (genvar k = 0; k < MAX_DEPTH; k++) begin : g_col
		if (k < CHUNK_DEPTH) begin : g_ram
			e1tdc_ram #(
				.WIDTH(8),
				.DEPTH(CHANNELS)
			) u_ram (
				.clk   (clk),
				.we    (wr_en && (frame_slot_q == 3'(k))),
				.waddr (AW'(slot_eff - 5'd1)),
				.wdata (in_data.data_byte),
				.re    (cmd.rd_issue),
				.raddr (AW'(rd_ch_q - 5'd1)),
				.rdata (rd_byte[k])
			);
		end else begin : g_zero
			assign rd_byte[k] = 8'd0;
		end
	end

	always_comb begin
		out_data.channel = out_ch_q;
		out_data.last = out_last_q;
		out_data.samples = '0;
		for (int k = 0; k < MAX_DEPTH; k++) begin
			out_data.samples[8*k +: 8] = rd_byte[k];
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: hdl/e1_timeslot_demux_chunker.sv
// E1 timeslot demultiplexer with corner turn.
// The input channel takes one payload byte of a received packet per item,
// with flags for the first byte of a packet and for a packet with bad status.
// Each packet opens with HEADER_BYTES header bytes, which are skipped; the
// rest forms 32-byte E1 frames. Timeslot 0 is dropped, timeslots 1 to
// CHANNELS are stored per frame. After CHUNK_DEPTH frames the output channel
// delivers CHANNELS items, one per channel, with the oldest sample lowest
// and last set on the final channel.
// While frames are being collected one byte is taken every cycle. The byte
// that completes a chunk starts a drain: the store is read one channel per
// cycle through its single read port. The first result appears once the
// state register has moved to the drain and the read has been registered.
// No byte is taken during the drain; the input is taken again from the
// cycle after the last read, while the final result may still wait.
// A receiver stall holds the current result and pauses the reads.
// Reset starts framing as if a packet had just begun; the store needs no
// clearing, as every entry read has been written within the same chunk.
module e1_timeslot_demux_chunker
	import e1tdc_pkg::*;
#(
	parameter int CHANNELS = 31,
	parameter int CHUNK_DEPTH = 8,
	parameter int HEADER_BYTES = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	e1tdc_cmd_t cmd;
	e1tdc_sts_t sts;

	e1tdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	e1tdc_datapath #(
		.CHANNELS     (CHANNELS),
		.CHUNK_DEPTH  (CHUNK_DEPTH),
		.HEADER_BYTES (HEADER_BYTES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	a_no_write_during_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && cmd.rd_issue))
		else $error("store read while bytes are being taken");

	a_last_on_final_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last == (out_data.channel == 5'(CHANNELS))))
		else $error("last flag does not match the final channel");

	a_drain_after_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take_byte && sts.chunk_end) |=> (!in_ready && sts.rd_last == (CHANNELS == 1)))
		else $error("drain did not start at the first channel");

	a_collect_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_issue && sts.rd_last) |=> (in_ready && out_valid))
		else $error("input not reopened after the final read");

endmodule
